// ===== hw/rtl/deq_pkg.sv =====
// Package for the double-ended queue: payload structs, operation, status and
// memory-command codes, and default sizes. No dependencies.
package deq_pkg;

  localparam int unsigned DEF_CAPACITY   = 1024;
  localparam int unsigned DEF_VALUE_BITS = 32;
  localparam int unsigned OP_BITS        = 3;
  localparam int unsigned DATA_BITS      = 32;
  localparam int unsigned POS_BITS       = 10;
  localparam int unsigned COUNT_BITS     = 11;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_POS   = 3'd4,
    OP_CLEAR      = 3'd5
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_WRITE = 2'd1,
    MEM_READ  = 2'd2
  } deq_mem_e;

  typedef struct packed {
    logic [OP_BITS-1:0]          operation;
    logic signed [DATA_BITS-1:0] push_value;
    logic [POS_BITS-1:0]         position;
  } deq_in_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [DATA_BITS-1:0] read_value;
    logic [COUNT_BITS-1:0]       count;
    logic                        is_empty;
  } deq_out_t;

  // Classified transaction handed from the front end to the back end
  typedef struct packed {
    deq_mem_e              mem_op;
    deq_status_e           status;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
  } deq_cmd_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/deq_cmd_fifo.sv =====
// Short command queue between front and back end of the deque.
// Depends on deq_pkg for its depth.
module deq_cmd_fifo
  import deq_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PTR_BITS = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(CMD_FIFO_DEPTH + 1);

  logic [WIDTH-1:0]    slot_q [CMD_FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] fill_q, fill_d;
  logic                push, pop;

  assign wr_ready_o = fill_q != CNT_BITS'(CMD_FIFO_DEPTH);
  assign rd_valid_o = fill_q != '0;
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/deq_front.sv =====
// Front end of the deque: accepts transactions, keeps front slot and count,
// works out status and ring address. Depends on deq_pkg.
module deq_front
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  deq_in_t                        in_data_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output deq_cmd_t                       cmd_o,
  output logic [$clog2(CAPACITY)-1:0]    addr_o,
  output logic [VALUE_BITS-1:0]          wdata_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_BITS) ? CW : POS_BITS;

  logic [AW-1:0]  front_q, front_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  offset;
  logic [AW:0]    ring_sum;
  logic [AW-1:0]  ring_slot;
  logic [AW-1:0]  front_dec;
  logic           full, empty, pos_bad, accept;
  logic signed [VALUE_BITS-1:0] push_trunc;

  assign accept      = in_valid_i && cmd_ready_i;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;

  assign full    = count_q == CW'(CAPACITY);
  assign empty   = count_q == '0;
  assign pos_bad = PW'(in_data_i.position) >= PW'(count_q);

  assign ring_sum  = {1'b0, front_q} + {1'b0, offset};
  assign ring_slot = (ring_sum >= (AW+1)'(CAPACITY)) ?
                     AW'(ring_sum - (AW+1)'(CAPACITY)) : AW'(ring_sum);
  assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - 1'b1;

  assign push_trunc = VALUE_BITS'(in_data_i.push_value);
  assign wdata_o    = push_trunc;

  always_comb begin
    front_d       = front_q;
    count_d       = count_q;
    offset        = '0;
    addr_o        = ring_slot;
    cmd_o.mem_op  = MEM_NONE;
    cmd_o.status  = ST_OK;
    unique case (in_data_i.operation)
      OP_PUSH_FRONT: begin
        addr_o = front_dec;
        if (full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.mem_op = MEM_WRITE;
          front_d      = front_dec;
          count_d      = count_q + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        offset = AW'(count_q);
        if (full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.mem_op = MEM_WRITE;
          count_d      = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        addr_o = front_q;
        offset = AW'(1);
        if (empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.mem_op = MEM_READ;
          front_d      = ring_slot;
          count_d      = count_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        offset = AW'(count_q - 1'b1);
        if (empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.mem_op = MEM_READ;
          count_d      = count_q - 1'b1;
        end
      end
      OP_READ_POS: begin
        offset = AW'(in_data_i.position);
        if (pos_bad) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.mem_op = MEM_READ;
        end
      end
      OP_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
    cmd_o.count    = COUNT_BITS'(count_d);
    cmd_o.is_empty = count_d == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (accept) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hw/rtl/deq_back.sv =====
// Back end of the deque: carries out the memory access of each queued
// transaction and holds the result register. Depends on deq_pkg, deq_ram.
module deq_back
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  deq_cmd_t                    cmd_i,
  input  logic [$clog2(CAPACITY)-1:0] addr_i,
  input  logic [VALUE_BITS-1:0]       wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output deq_out_t                    out_data_o
);

  logic                          fire, ram_en, ram_we;
  logic [VALUE_BITS-1:0]         rdata;
  logic signed [VALUE_BITS-1:0]  rdata_s;
  logic                          out_valid_q, out_valid_d;
  deq_cmd_t                      meta_q;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign ram_en      = fire && (cmd_i.mem_op != MEM_NONE);
  assign ram_we      = cmd_i.mem_op == MEM_WRITE;

  deq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr_i),
    .wdata_i (wdata_i),
    .rdata_o (rdata)
  );

  // rdata only moves on a read, so it holds while the result is stalled
  assign rdata_s = rdata;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      meta_q <= cmd_i;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.status     = meta_q.status;
  assign out_data_o.read_value = (meta_q.mem_op == MEM_READ) ? DATA_BITS'(rdata_s) : '0;
  assign out_data_o.count      = meta_q.count;
  assign out_data_o.is_empty   = meta_q.is_empty;

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: front end, command queue and
// back end with its store. Depends on deq_pkg, deq_front, deq_cmd_fifo, deq_back.
//
//   channel | signals                          | payload
//   in      | in_valid_i / in_ready_o          | deq_in_t  (operation, push_value, position)
//   out     | out_valid_o / out_ready_i        | deq_out_t (status, read_value, count, is_empty)
//
// One transaction per cycle unless stalled; each touches at most one single-port store word.
// A result passes the command queue, then the store read, on its way out.
// Reset clears front slot, count and handshake state; the store is not cleared.
// A stalled output holds the back end; the front keeps accepting until the queue fills.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  deq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output deq_out_t out_data_o
);

  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned QWIDTH = $bits(deq_cmd_t) + AW + VALUE_BITS;

  logic                  fq_valid, fq_ready, bq_valid, bq_ready;
  deq_cmd_t              f_cmd, b_cmd;
  logic [AW-1:0]         f_addr, b_addr;
  logic [VALUE_BITS-1:0] f_wdata, b_wdata;
  logic [QWIDTH-1:0]     q_wr, q_rd;

  deq_front #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (f_cmd),
    .addr_o      (f_addr),
    .wdata_o     (f_wdata)
  );

  assign q_wr = {f_cmd, f_addr, f_wdata};

  deq_cmd_fifo #(
    .WIDTH (QWIDTH)
  ) u_cmd_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (q_wr),
    .rd_valid_o (bq_valid),
    .rd_ready_i (bq_ready),
    .rd_data_o  (q_rd)
  );

  assign {b_cmd, b_addr, b_wdata} = q_rd;

  deq_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bq_valid),
    .cmd_ready_o (bq_ready),
    .cmd_i       (b_cmd),
    .addr_i      (b_addr),
    .wdata_i     (b_wdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for double_ended_queue: directed corner cases, a fill to
// capacity and a random mix, checked against a shadow ring held here.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int unsigned DEPTH = DEF_CAPACITY;
  localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    deq_in_t     data;
    int unsigned gap;
    bit          drain;
  } tx_item_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  deq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  deq_out_t out_data;
  logic     rx_hold = 1'b0;

  tx_item_t    pending_ops[$];
  deq_out_t    due_results[$];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned gen_count = 0;

  logic signed [DATA_BITS-1:0] shadow_words [DEPTH];
  logic [POS_BITS-1:0]         shadow_head = '0;
  logic [COUNT_BITS-1:0]       shadow_count = '0;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic deq_out_t apply_deq_op(deq_in_t op_in);
    deq_out_t            res;
    logic [POS_BITS-1:0] slot;
    res = '0;
    res.status = ST_OK;
    case (op_in.operation)
      OP_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_head = shadow_head - 1'b1;
          shadow_words[shadow_head] = op_in.push_value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = shadow_head + POS_BITS'(shadow_count);
          shadow_words[slot] = op_in.push_value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = shadow_words[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = shadow_head + POS_BITS'(shadow_count - 1'b1);
          res.read_value = shadow_words[slot];
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_READ_POS: begin
        if ({1'b0, op_in.position} >= shadow_count) begin
          res.status = ST_EMPTY;
        end else begin
          slot = shadow_head + op_in.position;
          res.read_value = shadow_words[slot];
        end
      end
      OP_CLEAR: begin
        shadow_head = '0;
        shadow_count = '0;
      end
      default: ;
    endcase
    res.count = shadow_count;
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic queue_item(input logic [OP_BITS-1:0] op, input logic [DATA_BITS-1:0] value,
                            input logic [POS_BITS-1:0] pos, input bit drain);
    tx_item_t it;
    it.data.operation  = op;
    it.data.push_value = value;
    it.data.position   = pos;
    it.gap   = tx_calm ? 0 : $urandom_range(0, 3);
    it.drain = drain;
    pending_ops.push_back(it);
    n_queued++;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_count < DEPTH) gen_count++;
      OP_POP_FRONT, OP_POP_BACK:   if (gen_count > 0) gen_count--;
      OP_CLEAR:                    gen_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_BITS-1:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    tx_item_t cur;
    bit       fire;
    if (rst_ni) begin
      fire = in_valid && in_ready;
      if (fire) begin
        due_results.push_back(apply_deq_op(in_data));
        n_accepted++;
        if (pending_ops.size() != 0) gap_cnt = pending_ops[0].gap;
      end
      if (!in_valid || fire) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain && due_results.size() != 0)) begin
          cur = pending_ops.pop_front();
          in_data  <= cur.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    deq_out_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          report_error($sformatf("unexpected transaction %0d", n_results));
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status)
            report_error($sformatf("result %0d status: exp %0d got %0d",
                                   n_results, want.status, out_data.status));
          if (out_data.read_value !== want.read_value)
            report_error($sformatf("result %0d read_value: exp %0d got %0d",
                                   n_results, want.read_value, out_data.read_value));
          if (out_data.count !== want.count)
            report_error($sformatf("result %0d count: exp %0d got %0d",
                                   n_results, want.count, out_data.count));
          if (out_data.is_empty !== want.is_empty)
            report_error($sformatf("result %0d is_empty: exp %0d got %0d",
                                   n_results, want.is_empty, out_data.is_empty));
        end
        if (n_results % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        stall_cnt = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (n_accepted >= 600);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic [OP_BITS-1:0] op;

    // directed: empty queue, spare codes, extremes, ring wrap at the front
    queue_item(OP_POP_FRONT, 32'h0, 10'd0, 1'b0);
    queue_item(OP_POP_BACK, 32'h0, 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd0, 1'b0);
    queue_item(OP_SPARE_6, 32'hffff_ffff, 10'h3ff, 1'b0);
    queue_item(OP_SPARE_7, 32'h1234_5678, 10'h155, 1'b0);
    queue_item(OP_PUSH_FRONT, 32'h7fff_ffff, 10'd0, 1'b0);
    queue_item(OP_PUSH_BACK, 32'h8000_0000, 10'd0, 1'b0);
    queue_item(OP_PUSH_FRONT, 32'h0, 10'd0, 1'b0);
    queue_item(OP_PUSH_BACK, 32'hffff_ffff, 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd1, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd2, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd3, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd4, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'h3ff, 1'b0);
    queue_item(OP_POP_BACK, 32'h0, 10'd0, 1'b0);
    queue_item(OP_POP_FRONT, 32'h0, 10'd0, 1'b0);
    queue_item(OP_POP_FRONT, 32'h0, 10'd0, 1'b0);
    queue_item(OP_POP_BACK, 32'h0, 10'd0, 1'b0);
    queue_item(OP_POP_FRONT, 32'h0, 10'd0, 1'b0);
    queue_item(OP_PUSH_BACK, 32'h5, 10'd0, 1'b0);
    queue_item(OP_CLEAR, 32'h0, 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd0, 1'b0);
    queue_item(OP_POP_BACK, 32'h0, 10'd0, 1'b0);

    // fill to capacity, full pushes, work at the wrap, then clear
    tx_calm = 1'b1;
    queue_item(OP_PUSH_BACK, draw_value(), 10'd0, 1'b1);
    tx_calm = 1'b0;
    while (gen_count < DEPTH)
      queue_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, draw_value(),
                 10'd0, 1'b0);
    queue_item(OP_PUSH_FRONT, draw_value(), 10'd0, 1'b0);
    queue_item(OP_PUSH_BACK, draw_value(), 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'h3ff, 1'b0);
    queue_item(OP_READ_POS, 32'h0, POS_BITS'($urandom_range(0, 1023)), 1'b0);
    queue_item(OP_POP_FRONT, 32'h0, 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'h3ff, 1'b0);
    queue_item(OP_PUSH_BACK, draw_value(), 10'd0, 1'b0);
    queue_item(OP_POP_BACK, 32'h0, 10'd0, 1'b0);
    queue_item(OP_PUSH_FRONT, draw_value(), 10'd0, 1'b0);
    queue_item(OP_PUSH_BACK, draw_value(), 10'd0, 1'b0);
    queue_item(OP_READ_POS, 32'h0, 10'h3ff, 1'b0);
    queue_item(OP_CLEAR, 32'h0, 10'd0, 1'b0);

    // random mix
    for (int unsigned i = 0; i < 150; i++) begin
      if (i % 50 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 22)      op = OP_PUSH_FRONT;
      else if (pick < 44) op = OP_PUSH_BACK;
      else if (pick < 60) op = OP_POP_FRONT;
      else if (pick < 74) op = OP_POP_BACK;
      else if (pick < 94) op = OP_READ_POS;
      else if (pick < 96) op = OP_CLEAR;
      else if (pick < 98) op = OP_SPARE_6;
      else                op = OP_SPARE_7;
      queue_item(op, draw_value(),
                 POS_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                           : $urandom_range(0, (gen_count > 1023) ? 1023 : gen_count)),
                 1'b0);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_accepted == n_queued);
    wait (due_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (due_results.size() != 0)
      report_error($sformatf("%0d results never arrived", due_results.size()));
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
